// ----- rtl/ftpt_pkg.sv -----
`timescale 1ns / 1ps

package ftpt_pkg;

  localparam int MAX_FRAME_BYTES = 64;
  localparam int BANK_BYTES      = 64;
  localparam int IDX_W           = $clog2(BANK_BYTES);
  localparam int LEN_W           = 7;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FRAME_BYTES);

  localparam logic [2:0] F_LOAD      = 3'd0;
  localparam logic [2:0] F_START     = 3'd1;
  localparam logic [2:0] F_WRITABLE  = 3'd2;
  localparam logic [2:0] F_DRV_FAULT = 3'd3;
  localparam logic [2:0] F_CANCEL    = 3'd4;
  localparam logic [2:0] F_POLL      = 3'd5;

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_PENDING   = 3'd1;
  localparam logic [2:0] ST_COMPLETED = 3'd2;
  localparam logic [2:0] ST_TIMEOUT   = 3'd3;
  localparam logic [2:0] ST_FAULT     = 3'd4;
  localparam logic [2:0] ST_BUSY      = 3'd5;
  localparam logic [2:0] ST_INVALID   = 3'd6;

  typedef struct packed {
    logic accept;
    logic rd_issue;
  } ftpt_cmd_t;

  typedef struct packed {
    logic stream;
    logic more;
  } ftpt_sts_t;

endpackage

// ----- rtl/ftpt_dp.sv -----
`timescale 1ns / 1ps

module ftpt_dp import ftpt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  ftpt_cmd_t         cmd,
  output ftpt_sts_t         sts,
  input  logic [2:0]        in_func,
  input  logic [IDX_W-1:0]  in_byte_index,
  input  logic [7:0]        in_data_byte,
  input  logic [LEN_W-1:0]  in_frame_length,
  input  logic [63:0]       in_now_us,
  input  logic [63:0]       in_timeout_us,
  input  logic signed [7:0] in_written_count,
  output logic [2:0]        out_status,
  output logic [7:0]        out_tx_byte,
  output logic              out_byte_valid,
  output logic              out_stop_port,
  output logic              out_last
);

  logic [2:0]       tx_state_r, tx_state_nxt;
  logic             bank_r, bank_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] acc_r, acc_nxt;
  logic [63:0]      lp_r, lp_nxt;
  logic [63:0]      tmo_r, tmo_nxt;

  logic [2:0]       fin_status_r;
  logic             fin_stop_r;
  logic             byte_mode_r;
  logic [IDX_W-1:0] ptr_r;
  logic [LEN_W-1:0] left_r;
  logic [7:0]       rd_data_r;
  logic [7:0]       mem [0:2*BANK_BYTES-1];

  logic [LEN_W-1:0] remaining;
  logic [LEN_W-1:0] acc_sum;
  logic [63:0]      elapsed;
  logic             bad_count;
  logic             bad_start;
  logic [2:0]       status_c;
  logic             stop_c;
  logic             stream_c;

  assign remaining = len_r - acc_r;
  assign acc_sum   = acc_r + in_written_count[LEN_W-1:0];
  assign elapsed   = in_now_us - lp_r;
  assign bad_count = in_written_count[7] || (in_written_count[6:0] == 7'd0) ||
                     (in_written_count[LEN_W-1:0] > remaining);
  assign bad_start = (in_frame_length == '0) || (in_frame_length > MAX_LEN) ||
                     (in_timeout_us == 64'd0);

  always_comb begin
    tx_state_nxt = tx_state_r;
    bank_nxt     = bank_r;
    len_nxt      = len_r;
    acc_nxt      = acc_r;
    lp_nxt       = lp_r;
    tmo_nxt      = tmo_r;
    status_c     = tx_state_r;
    stop_c       = 1'b0;
    stream_c     = 1'b0;
    case (in_func)
      F_LOAD: begin
        status_c = tx_state_r;
      end
      F_START: begin
        if (bad_start) begin
          status_c = ST_INVALID;
        end else if (tx_state_r != ST_IDLE) begin
          status_c = ST_BUSY;
        end else begin
          bank_nxt     = ~bank_r;
          len_nxt      = in_frame_length;
          acc_nxt      = '0;
          lp_nxt       = in_now_us;
          tmo_nxt      = in_timeout_us;
          tx_state_nxt = ST_PENDING;
          status_c     = ST_PENDING;
        end
      end
      F_WRITABLE: begin
        stop_c = 1'b1;
        if (tx_state_r == ST_PENDING) begin
          if (bad_count) begin
            tx_state_nxt = ST_FAULT;
            status_c     = ST_FAULT;
          end else begin
            stream_c = 1'b1;
            acc_nxt  = acc_sum;
            lp_nxt   = in_now_us;
            if (acc_sum == len_r) begin
              tx_state_nxt = ST_COMPLETED;
              status_c     = ST_COMPLETED;
            end else begin
              status_c = ST_PENDING;
              stop_c   = 1'b0;
            end
          end
        end
      end
      F_DRV_FAULT: begin
        if (tx_state_r == ST_PENDING) begin
          tx_state_nxt = ST_FAULT;
          status_c     = ST_FAULT;
          stop_c       = 1'b1;
        end
      end
      F_CANCEL: begin
        stop_c       = (tx_state_r == ST_PENDING);
        status_c     = ST_IDLE;
        tx_state_nxt = ST_IDLE;
        len_nxt      = '0;
        acc_nxt      = '0;
        lp_nxt       = '0;
        tmo_nxt      = '0;
      end
      F_POLL: begin
        if ((tx_state_r == ST_PENDING) && (elapsed >= tmo_r)) begin
          status_c = ST_TIMEOUT;
          stop_c   = 1'b1;
        end
        if ((status_c == ST_COMPLETED) || (status_c == ST_TIMEOUT) ||
            (status_c == ST_FAULT)) begin
          tx_state_nxt = ST_IDLE;
          len_nxt      = '0;
          acc_nxt      = '0;
          lp_nxt       = '0;
          tmo_nxt      = '0;
        end
      end
      default: begin
        status_c = tx_state_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_state_r <= ST_IDLE;
      bank_r     <= 1'b0;
      len_r      <= '0;
      acc_r      <= '0;
      lp_r       <= '0;
      tmo_r      <= '0;
    end else if (cmd.accept) begin
      tx_state_r <= tx_state_nxt;
      bank_r     <= bank_nxt;
      len_r      <= len_nxt;
      acc_r      <= acc_nxt;
      lp_r       <= lp_nxt;
      tmo_r      <= tmo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      fin_status_r <= status_c;
      fin_stop_r   <= stop_c;
      byte_mode_r  <= stream_c;
      ptr_r        <= acc_r[IDX_W-1:0];
      left_r       <= in_written_count[LEN_W-1:0];
    end else if (cmd.rd_issue) begin
      ptr_r  <= ptr_r + 1'b1;
      left_r <= left_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && (in_func == F_LOAD)) begin
      mem[{~bank_r, in_byte_index}] <= in_data_byte;
    end
    if (cmd.rd_issue) begin
      rd_data_r <= mem[{bank_r, ptr_r}];
    end
  end

  assign sts.stream = stream_c;
  assign sts.more   = byte_mode_r && (left_r != '0);

  assign out_last       = !byte_mode_r || (left_r == '0);
  assign out_status     = out_last ? fin_status_r : ST_PENDING;
  assign out_stop_port  = out_last && fin_stop_r;
  assign out_tx_byte    = byte_mode_r ? rd_data_r : 8'd0;
  assign out_byte_valid = byte_mode_r;

  a_stream_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && sts.stream) |=> (left_r != '0))
    else $error("byte transfer started with nothing to send");

endmodule

// ----- rtl/ftpt_ctrl.sv -----
`timescale 1ns / 1ps

module ftpt_ctrl import ftpt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output ftpt_cmd_t cmd,
  input  ftpt_sts_t sts
);

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_RD   = 2'd1;
  localparam logic [1:0] C_OUT  = 2'd2;

  logic [1:0] st_r, st_nxt;

  always_comb begin
    st_nxt       = st_r;
    cmd.accept   = 1'b0;
    cmd.rd_issue = 1'b0;
    case (st_r)
      C_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          st_nxt     = sts.stream ? C_RD : C_OUT;
        end
      end
      C_RD: begin
        cmd.rd_issue = 1'b1;
        st_nxt       = C_OUT;
      end
      C_OUT: begin
        if (!out_stall) begin
          if (sts.more) begin
            cmd.rd_issue = 1'b1;
          end else begin
            st_nxt = C_IDLE;
          end
        end
      end
      default: begin
        st_nxt = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= C_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign in_stall  = (st_r != C_IDLE);
  assign out_valid = (st_r == C_OUT);

  a_read_then_out: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == C_RD) |=> (st_r == C_OUT))
    else $error("read stage not followed by output stage");

  a_stream_reads_first: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && sts.stream) |=> (st_r == C_RD))
    else $error("byte stream did not begin with a read");

  a_stall_holds_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> (!cmd.rd_issue ##1 out_valid))
    else $error("result dropped or overwritten while stalled");

endmodule

// ----- rtl/frame_tx_progress_timeout.sv -----
`timescale 1ns / 1ps
// Frame transmitter with a progress watchdog.
// The input channel carries one command per transfer: load a byte into the
// staging bank, start a frame, report a writable event, report a driver
// fault, cancel, or poll the watchdog. The result channel returns status
// items, with a last flag on the final item caused by each command.
// Every command except a successful writable event gives one result in the
// cycle after it is taken, and the next command can be taken in the cycle
// after that result is transferred.
// A writable event that sends n bytes gives n results, one per cycle while
// the receiver takes them, after a frame store read.
// The single-port frame store read, registered, sets that pace.
// Only one command is in flight at a time; in_stall is high until its last
// result has been transferred.
// A synchronous reset returns the transmitter to idle with bank zero active;
// the frame store contents are not cleared and must be loaded before use.
// While the receiver stalls, the pending result is held unchanged.

module frame_tx_progress_timeout import ftpt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_func,
  input  logic [IDX_W-1:0]  in_byte_index,
  input  logic [7:0]        in_data_byte,
  input  logic [LEN_W-1:0]  in_frame_length,
  input  logic [63:0]       in_now_us,
  input  logic [63:0]       in_timeout_us,
  input  logic signed [7:0] in_written_count,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_status,
  output logic [7:0]        out_tx_byte,
  output logic              out_byte_valid,
  output logic              out_stop_port,
  output logic              out_last
);

  ftpt_cmd_t cmd;
  ftpt_sts_t sts;

  ftpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  ftpt_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_func          (in_func),
    .in_byte_index    (in_byte_index),
    .in_data_byte     (in_data_byte),
    .in_frame_length  (in_frame_length),
    .in_now_us        (in_now_us),
    .in_timeout_us    (in_timeout_us),
    .in_written_count (in_written_count),
    .out_status       (out_status),
    .out_tx_byte      (out_tx_byte),
    .out_byte_valid   (out_byte_valid),
    .out_stop_port    (out_stop_port),
    .out_last         (out_last)
  );

endmodule
